>>> design/adjdfs_pkg.sv
`default_nettype none
package adjdfs_pkg;

  // node indices on the ports are four bits wide, so edges live in a 16 x 16 matrix
  localparam int IDX_W         = 4;
  localparam int IDX_SPAN      = 1 << IDX_W;
  localparam int LABEL_W       = 8;
  localparam int DEF_MAX_NODES = 16;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [IDX_SPAN-1:0] mask_t;
  typedef logic [LABEL_W-1:0]  label_t;

  typedef enum logic [1:0] {
    OP_ADD_NODE   = 2'd0,
    OP_ADD_EDGE   = 2'd1,
    OP_CHECK_EDGE = 2'd2,
    OP_SEARCH     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_NODE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_LBL  = 4'b0100,
    S_WALK = 4'b1000
  } state_t;

  // sequencer to graph store
  typedef struct packed {
    logic   add_node;
    logic   add_edge;
    logic   lbl_rd_en;
    label_t label;
    idx_t   src;
    idx_t   dst;
    idx_t   row_sel;
    idx_t   lbl_raddr;
  } store_req_t;

  // graph store to sequencer
  typedef struct packed {
    mask_t  node_mask;
    logic   full;
    mask_t  row;
    label_t lbl_rdata;
  } store_rsp_t;

  typedef struct packed {
    status_t status;
    logic    edge_present;
    idx_t    visit_index;
    label_t  visit_label;
    logic    last;
  } result_t;

endpackage
`default_nettype wire

>>> design/adjacency_matrix_dfs.sv
// directed graph in a bit adjacency matrix with a depth-first search engine
//
// input channel (in_valid/in_ready) takes one opcode transaction at a time:
// add node (label_in), add edge and check edge (src_node, dst_node), or a
// depth-first search from src_node. in_ready is high only while idle.
// output channel (out_valid/out_ready) gives status, edge_present,
// visit_index, visit_label and last; last marks the final result of a
// transaction. add node, add edge, check edge and a bad search source give
// one result, registered from the execute state once the output register is
// free; in_ready returns when the block is back in idle. a search gives one
// result per newly visited node in pre-order; each visited node takes a
// label memory read state and a neighbour pick state, and each stack pop a
// walk step of its own, set by the single-step neighbour picker and the label
// memory port. reset clears the adjacency matrix and node count; labels are
// undefined until written. a stalled receiver holds the output register and
// the walk waits at the next result, so nothing is lost or repeated.
`default_nettype none
module adjacency_matrix_dfs #(
  parameter int MAX_NODES = adjdfs_pkg::DEF_MAX_NODES
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [1:0] opcode,
  input  wire  [3:0] src_node,
  input  wire  [3:0] dst_node,
  input  wire  [7:0] label_in,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [1:0] status,
  output logic       edge_present,
  output logic [3:0] visit_index,
  output logic [7:0] visit_label,
  output logic       last
);
  import adjdfs_pkg::*;

  store_req_t store_req;
  store_rsp_t store_rsp;
  logic       out_free;
  logic       res_push;
  result_t    res;

  // output register frees up in the same cycle it is taken
  assign out_free = !out_valid || out_ready;

  adjdfs_store #(
    .MAX_NODES(MAX_NODES)
  ) u_store (
    .clk (clk),
    .rst (rst),
    .req (store_req),
    .rsp (store_rsp)
  );

  adjdfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .src_node  (src_node),
    .dst_node  (dst_node),
    .label_in  (label_in),
    .store_req (store_req),
    .store_rsp (store_rsp),
    .out_free  (out_free),
    .res_push  (res_push),
    .res       (res)
  );

  // output register, valid cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      status       <= res.status;
      edge_present <= res.edge_present;
      visit_index  <= res.visit_index;
      visit_label  <= res.visit_label;
      last         <= res.last;
    end
  end

endmodule
`default_nettype wire

>>> design/adjdfs_store.sv
`default_nettype none
module adjdfs_store #(
  parameter int MAX_NODES = adjdfs_pkg::DEF_MAX_NODES
) (
  input  wire                    clk,
  input  wire                    rst,
  input  adjdfs_pkg::store_req_t req,
  output adjdfs_pkg::store_rsp_t rsp
);
  import adjdfs_pkg::*;

  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int LBL_AW = $clog2(MAX_NODES);

  mask_t              adj [IDX_SPAN];
  logic [CNT_W-1:0]   node_count;
  label_t             labels [MAX_NODES];
  label_t             lbl_rdata;

  // adjacency matrix and node count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < IDX_SPAN; i++) begin
        adj[i] <= '0;
      end
      node_count <= '0;
    end else begin
      if (req.add_edge) begin
        adj[req.src][req.dst] <= 1'b1;
      end
      if (req.add_node) begin
        node_count <= node_count + CNT_W'(1);
      end
    end
  end

  // label memory, registered read
  always_ff @(posedge clk) begin
    if (req.add_node) begin
      labels[LBL_AW'(node_count)] <= req.label;
    end
    if (req.lbl_rd_en) begin
      lbl_rdata <= labels[LBL_AW'(req.lbl_raddr)];
    end
  end

  always_comb begin
    for (int i = 0; i < IDX_SPAN; i++) begin
      rsp.node_mask[i] = (int'(node_count) > i);
    end
    rsp.full      = (node_count == CNT_W'(MAX_NODES));
    rsp.row       = adj[req.row_sel];
    rsp.lbl_rdata = lbl_rdata;
  end

endmodule
`default_nettype wire

>>> design/adjdfs_ctrl.sv
`default_nettype none
module adjdfs_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire [1:0]              opcode,
  input  wire [3:0]              src_node,
  input  wire [3:0]              dst_node,
  input  wire [7:0]              label_in,
  output adjdfs_pkg::store_req_t store_req,
  input  adjdfs_pkg::store_rsp_t store_rsp,
  input  wire                    out_free,
  output logic                   res_push,
  output adjdfs_pkg::result_t    res
);
  import adjdfs_pkg::*;

  state_t state, state_next;

  op_t    op_q;
  idx_t   src_q;
  idx_t   dst_q;
  label_t label_q;

  mask_t          visited;
  idx_t           cur;
  idx_t           stack [IDX_SPAN];
  logic [IDX_W:0] sp;
  idx_t           pend_idx;
  label_t         pend_label;

  mask_t cand;
  logic  cand_any;
  idx_t  nxt;
  idx_t  sp_top;
  logic  ends_ok;

  assign in_ready = (state == S_IDLE);
  assign sp_top   = IDX_W'(sp - (IDX_W+1)'(1));
  assign ends_ok  = store_rsp.node_mask[src_q] & store_rsp.node_mask[dst_q];

  // unvisited neighbours of the current node, lowest index first
  assign cand     = store_rsp.row & ~visited & store_rsp.node_mask;
  assign cand_any = |cand;

  always_comb begin
    nxt = '0;
    for (int i = IDX_SPAN - 1; i >= 0; i--) begin
      if (cand[i]) nxt = IDX_W'(i);
    end
  end

  always_comb begin
    state_next          = state;
    res_push            = 1'b0;
    res                 = '0;
    res.status          = ST_OK;
    store_req           = '0;
    store_req.label     = label_q;
    store_req.src       = src_q;
    store_req.dst       = dst_q;
    store_req.row_sel   = (state == S_WALK) ? cur : src_q;
    store_req.lbl_raddr = (state == S_EXEC) ? src_q : nxt;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          res.last   = 1'b1;
          state_next = S_IDLE;
          case (op_q)
            OP_ADD_NODE: begin
              res_push           = 1'b1;
              res.status         = store_rsp.full ? ST_FULL : ST_OK;
              store_req.add_node = !store_rsp.full;
            end
            OP_ADD_EDGE: begin
              res_push           = 1'b1;
              res.status         = ends_ok ? ST_OK : ST_NOT_NODE;
              store_req.add_edge = ends_ok;
            end
            OP_CHECK_EDGE: begin
              res_push         = 1'b1;
              res.status       = ends_ok ? ST_OK : ST_NOT_NODE;
              res.edge_present = ends_ok & store_rsp.row[dst_q];
            end
            OP_SEARCH: begin
              if (store_rsp.node_mask[src_q]) begin
                store_req.lbl_rd_en = 1'b1;
                state_next          = S_LBL;
              end else begin
                res_push   = 1'b1;
                res.status = ST_NOT_NODE;
              end
            end
            default: ;
          endcase
        end
      end
      S_LBL: begin
        state_next = S_WALK;
      end
      S_WALK: begin
        res.visit_index = pend_idx;
        res.visit_label = pend_label;
        if (cand_any) begin
          if (out_free) begin
            res_push            = 1'b1;
            store_req.lbl_rd_en = 1'b1;
            state_next          = S_LBL;
          end
        end else if (sp == '0) begin
          if (out_free) begin
            res_push   = 1'b1;
            res.last   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sp      <= '0;
      visited <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC && state_next == S_LBL) begin
        visited  <= mask_t'(1) << src_q;
        cur      <= src_q;
        pend_idx <= src_q;
        sp       <= '0;
      end
      if (state == S_WALK) begin
        if (cand_any) begin
          if (out_free) begin
            visited   <= visited | (mask_t'(1) << nxt);
            stack[IDX_W'(sp)] <= cur;
            sp        <= sp + (IDX_W+1)'(1);
            cur       <= nxt;
            pend_idx  <= nxt;
          end
        end else if (sp != '0) begin
          cur <= stack[sp_top];
          sp  <= sp - (IDX_W+1)'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q    <= op_t'(opcode);
      src_q   <= src_node;
      dst_q   <= dst_node;
      label_q <= label_in;
    end
    if (state == S_LBL) begin
      pend_label <= store_rsp.lbl_rdata;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> out_free)
    else $error("result pushed into a full output register");

  a_idle_stack_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (sp == '0))
    else $error("stack not empty between transactions");

  a_cur_visited: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> visited[cur])
    else $error("walking from an unvisited node");

  a_visited_nodes: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ((visited & ~store_rsp.node_mask) == '0))
    else $error("visited mark on an index that is not a node");

endmodule
`default_nettype wire
